// ===== rtl/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, character codes and per-slot field tables for the
// datetime string parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

	// separator must sit below this offset from the field start
	localparam int unsigned SepWindow  = 10;
	localparam int unsigned NumSlots   = 6;
	localparam logic [2:0]  FieldsFull = 3'd6;
	localparam logic [2:0]  FieldsTime = 3'd3;
	localparam logic [2:0]  BaseFull   = 3'd0;
	localparam logic [2:0]  BaseTime   = 3'd3;
	localparam logic [2:0]  SlotYear   = 3'd0;
	localparam logic [15:0] YearOffset = 16'd2000;
	localparam logic [15:0] TimeLimit  = 16'd100;
	localparam logic [15:0] AccMax     = 16'hFFFF;
	localparam logic [3:0]  CountMax   = 4'd15;

	// format modes
	localparam logic MODE_DATETIME = 1'b0;
	localparam logic MODE_TIME     = 1'b1;

	// character codes
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChT     = 8'h54;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChNone  = 8'h00;

	typedef enum logic [1:0] {
		PH_SPACE  = 2'd0,
		PH_DIGITS = 2'd1,
		PH_SEEK   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} item_t;

	typedef struct packed {
		logic       status;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
	} result_t;

	// separator that closes each slot
	function automatic logic [7:0] sep_of_slot(input logic [2:0] slot);
		logic [7:0] s;
		unique case (slot)
			3'd0, 3'd1: s = ChDash;
			3'd2:       s = ChT;
			3'd3, 3'd4: s = ChColon;
			default:    s = ChNone;
		endcase
		return s;
	endfunction

	// lower range bound per slot in datetime mode
	function automatic logic [15:0] lo_of_slot(input logic [2:0] slot);
		logic [15:0] v;
		unique case (slot)
			3'd1, 3'd2: v = 16'd1;
			default:    v = 16'd0;
		endcase
		return v;
	endfunction

	// upper range bound per slot in datetime mode
	function automatic logic [15:0] hi_of_slot(input logic [2:0] slot);
		logic [15:0] v;
		unique case (slot)
			3'd0:       v = 16'd99;
			3'd1:       v = 16'd12;
			3'd2:       v = 16'd31;
			3'd3:       v = 16'd23;
			default:    v = 16'd59;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/datetime_string_parser_unit.sv =====
// ----------------------------------------------------------------------------
// datetime_string_parser_unit
// Streaming parser for "YY-MM-DDTHH:mm:ss" and "HH:mm:ss" text.
// ----------------------------------------------------------------------------
// Takes ASCII characters and gives one result per string, on the character
// marked is_last. Each accepted character is registered, then the parse state
// is updated, so the sustained rate is one character per clock while in_ready
// is high. The result is registered once the last character leaves the input
// register. in_ready drops only when a last character is waiting while the
// output register still holds an untaken result. format_mode (0 datetime, 1
// time only) is written through the configuration channel, which is always
// ready; write it only between strings.
// ----------------------------------------------------------------------------
module datetime_string_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       format_mode,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic [6:0] year,
	output logic [3:0] month,
	output logic [4:0] day,
	output logic [6:0] hours,
	output logic [6:0] minutes,
	output logic [6:0] seconds
);

	dtp_pkg::item_t   item;
	dtp_pkg::item_t   item_s1;
	dtp_pkg::result_t result;
	dtp_pkg::result_t result_q;
	logic             valid_s1;
	logic             step;

	assign cfg_ready = 1'b1;
	assign item      = '{char_code: char_code, is_last: is_last};

	// a last character waits only for room in the output register
	assign step = valid_s1 && (!item_s1.is_last || !out_valid || out_ready);

	dtp_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.consume  (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dtp_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (format_mode),
		.step     (step),
		.item_s1  (item_s1),
		.result   (result)
	);

	dtp_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && item_s1.is_last),
		.result    (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	// output fields
	assign status  = result_q.status;
	assign year    = result_q.year;
	assign month   = result_q.month;
	assign day     = result_q.day;
	assign hours   = result_q.hours;
	assign minutes = result_q.minutes;
	assign seconds = result_q.seconds;

endmodule

// ===== rtl/dtp_input_stage.sv =====
// ----------------------------------------------------------------------------
// dtp_input_stage
// Input register: holds one accepted character until the parse core
// consumes it.
// ----------------------------------------------------------------------------
module dtp_input_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dtp_pkg::item_t item,
	input  logic          consume,
	output logic          valid_s1,
	output dtp_pkg::item_t item_s1
);

	// free slot or slot emptied this cycle
	assign in_ready = !valid_s1 || consume;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload on transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== rtl/dtp_parse_core.sv =====
// ----------------------------------------------------------------------------
// dtp_parse_core
// Field parser state and its update for one character,
// plus the result word formed on the final character.
// ----------------------------------------------------------------------------
module dtp_parse_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_data,
	input  logic             step,
	input  dtp_pkg::item_t   item_s1,
	output dtp_pkg::result_t result
);

	logic                mode_q;
	logic [2:0]          fi_q;
	dtp_pkg::phase_t     phase_q;
	logic [15:0]         acc_q;
	logic [3:0]          cif_q;
	logic                err_q;
	logic [6:0]          store_q [dtp_pkg::NumSlots];

	logic [2:0]          n_fi;
	dtp_pkg::phase_t     n_phase;
	logic [15:0]         n_acc;
	logic [3:0]          n_cif;
	logic                n_err;
	logic [6:0]          n_store [dtp_pkg::NumSlots];

	logic [2:0]          count;
	logic [2:0]          base;
	logic [2:0]          slot;
	logic [2:0]          end_slot;
	logic                digit;
	logic                final_field;
	logic                sep_hit;
	logic [19:0]         prod;
	logic                ok1;
	logic [6:0]          val1;
	logic                ok2;
	logic [6:0]          val2;
	logic [2:0]          fi_end;
	logic                err_end;

	// range check of a closed number
	function automatic logic [7:0] close_check(input logic mode, input logic [2:0] s,
			input logic [15:0] acc);
		logic [15:0] v;
		logic        ok;
		v = acc;
		if (mode == dtp_pkg::MODE_TIME) begin
			ok = v < dtp_pkg::TimeLimit;
		end else begin
			if (s == dtp_pkg::SlotYear && v > dtp_pkg::YearOffset) begin
				v = v - dtp_pkg::YearOffset;
			end
			ok = v >= dtp_pkg::lo_of_slot(s) && v <= dtp_pkg::hi_of_slot(s);
		end
		return {ok, v[6:0]};
	endfunction

	// mode dependent field count and slot base
	assign count = (mode_q == dtp_pkg::MODE_TIME) ? dtp_pkg::FieldsTime : dtp_pkg::FieldsFull;
	assign base  = (mode_q == dtp_pkg::MODE_TIME) ? dtp_pkg::BaseTime : dtp_pkg::BaseFull;
	assign slot  = base + fi_q;

	assign digit       = item_s1.char_code >= dtp_pkg::ChZero &&
	                     item_s1.char_code <= dtp_pkg::ChNine;
	assign final_field = (fi_q + 3'd1) == count;
	assign sep_hit     = item_s1.char_code == dtp_pkg::sep_of_slot(slot) &&
	                     cif_q < 4'(dtp_pkg::SepWindow);
	assign prod        = 20'(acc_q) * 20'd10 + 20'(item_s1.char_code[3:0]);
	assign {ok1, val1} = close_check(mode_q, slot, acc_q);

	// per-character state update
	always_comb begin
		logic advanced;
		advanced = 1'b0;
		n_fi     = fi_q;
		n_phase  = phase_q;
		n_acc    = acc_q;
		n_cif    = cif_q;
		n_err    = err_q;
		n_store  = store_q;
		if (!err_q && fi_q < count) begin
			unique case (phase_q)
				dtp_pkg::PH_SPACE: begin
					if (digit) begin
						n_acc   = 16'(item_s1.char_code[3:0]);
						n_phase = dtp_pkg::PH_DIGITS;
					end else if (item_s1.char_code != dtp_pkg::ChSpace) begin
						n_err = 1'b1;
					end
				end
				dtp_pkg::PH_DIGITS: begin
					if (digit) begin
						n_acc = (prod > 20'(dtp_pkg::AccMax)) ? dtp_pkg::AccMax : prod[15:0];
					end else if (!ok1) begin
						n_err = 1'b1;
					end else begin
						if (slot < 3'(dtp_pkg::NumSlots)) begin
							n_store[slot] = val1;
						end
						if (final_field || sep_hit) begin
							advanced = 1'b1;
						end else begin
							n_phase = dtp_pkg::PH_SEEK;
						end
					end
				end
				default: begin
					if (!final_field && sep_hit) begin
						advanced = 1'b1;
					end
				end
			endcase
			if (advanced) begin
				n_fi    = fi_q + 3'd1;
				n_phase = dtp_pkg::PH_SPACE;
				n_acc   = '0;
				n_cif   = '0;
			end else if (cif_q < dtp_pkg::CountMax) begin
				n_cif = cif_q + 4'd1;
			end
		end
	end

	// closing of the final field on the last character
	assign end_slot    = base + n_fi;
	assign {ok2, val2} = close_check(mode_q, end_slot, n_acc);

	always_comb begin
		logic closing;
		closing = !n_err && (n_fi + 3'd1) == count && n_phase == dtp_pkg::PH_DIGITS;
		fi_end  = n_fi;
		err_end = n_err;
		if (closing) begin
			if (ok2) begin
				fi_end = n_fi + 3'd1;
			end else begin
				err_end = 1'b1;
			end
		end
	end

	// result word: fields only when the whole string parsed
	always_comb begin
		logic [6:0] st [dtp_pkg::NumSlots];
		st = n_store;
		if (!err_end && (n_fi + 3'd1) == count && n_phase == dtp_pkg::PH_DIGITS &&
				end_slot < 3'(dtp_pkg::NumSlots)) begin
			st[end_slot] = val2;
		end
		if (!err_end && fi_end >= count) begin
			result.status  = 1'b0;
			result.year    = st[0];
			result.month   = st[1][3:0];
			result.day     = st[2][4:0];
			result.hours   = st[3];
			result.minutes = st[4];
			result.seconds = st[5];
		end else begin
			result = '0;
			result.status = 1'b1;
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dtp_pkg::MODE_DATETIME;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	// parse state, cleared at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q    <= '0;
			phase_q <= dtp_pkg::PH_SPACE;
			acc_q   <= '0;
			cif_q   <= '0;
			err_q   <= 1'b0;
			store_q <= '{default: '0};
		end else if (step) begin
			if (item_s1.is_last) begin
				fi_q    <= '0;
				phase_q <= dtp_pkg::PH_SPACE;
				acc_q   <= '0;
				cif_q   <= '0;
				err_q   <= 1'b0;
				store_q <= '{default: '0};
			end else begin
				fi_q    <= n_fi;
				phase_q <= n_phase;
				acc_q   <= n_acc;
				cif_q   <= n_cif;
				err_q   <= n_err;
				store_q <= n_store;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.is_last |=> fi_q == '0 && !err_q && acc_q == '0 && cif_q == '0)
		else $error("parse state not cleared after last character");
	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fi_q <= dtp_pkg::FieldsFull)
		else $error("field index beyond last field");
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.status |-> result.year == '0 && result.month == '0 && result.day == '0 &&
			result.hours == '0 && result.minutes == '0 && result.seconds == '0)
		else $error("error result carries non-zero fields");
`endif

endmodule

// ===== rtl/dtp_result_reg.sv =====
// ----------------------------------------------------------------------------
// dtp_result_reg
// Output register holding one result until its transfer completes.
// ----------------------------------------------------------------------------
module dtp_result_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  dtp_pkg::result_t result,
	output logic             out_valid,
	input  logic             out_ready,
	output dtp_pkg::result_t result_q
);

	logic valid_q;

	assign out_valid = valid_q;

	// valid flag: set on load, dropped after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule
